// ===== rtl/dual_index_barcode_matcher_unit_assert.svh =====
// Assertion macros, clocked on clk_i and disabled while rst_ni is low
`ifndef DUAL_INDEX_BARCODE_MATCHER_UNIT_ASSERT_SVH
`define DUAL_INDEX_BARCODE_MATCHER_UNIT_ASSERT_SVH

`define DIBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define DIBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dibm_pkg.sv =====
package dibm_pkg;

  localparam int unsigned LANES            = 8;
  localparam int unsigned SAMPLES_PER_LANE = 64;
  localparam int unsigned INDEX_BASES      = 10;

  localparam int unsigned IDX_W  = 30;
  localparam int unsigned BASE_W = 3;
  localparam int unsigned SLOT_W = 7;
  localparam int unsigned CFG_W  = 4;
  localparam int unsigned CIDX_W = 2;

  localparam logic CMD_INSERT   = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  localparam logic [CIDX_W-1:0] REG_MAX_ERRORS   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_INDEX_LENGTH = 2'd1;

  localparam logic [CFG_W-1:0] MAX_ERRORS_RST   = 4'd1;
  localparam logic [CFG_W-1:0] INDEX_LENGTH_RST = 4'd8;

  typedef enum logic [2:0] {
    ST_MATCHED      = 3'd0,
    ST_UNDETERMINED = 3'd1,
    ST_NO_LANE      = 3'd2,
    ST_INSERTED     = 3'd3,
    ST_FULL         = 3'd4
  } status_e;

  typedef struct packed {
    logic [IDX_W-1:0] w7;
    logic [IDX_W-1:0] w5;
  } pair_t;

endpackage

// ===== rtl/dual_index_barcode_matcher_unit.sv =====
// Dual-index barcode matcher. Insert items append an i7/i5 pair to a lane's table
// if it has room and go from idle straight to the result state; reads of unknown or empty lanes
// do the same. A classify read of a lane holding N entries streams those entries one a cycle
// out of the single-port table memory through a chain of INDEX_BASES base-compare cells. The
// table memory port sets that rate: one entry is read per cycle. Results wait in an output
// register while the next item is taken.
`include "dual_index_barcode_matcher_unit_assert.svh"

module dual_index_barcode_matcher_unit #(
  parameter int unsigned LANES            = dibm_pkg::LANES,
  parameter int unsigned SAMPLES_PER_LANE = dibm_pkg::SAMPLES_PER_LANE,
  parameter int unsigned INDEX_BASES      = dibm_pkg::INDEX_BASES
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         in_command_i,
  input  logic [3:0]                   in_lane_i,
  input  logic [dibm_pkg::IDX_W-1:0]   in_first_index_i,
  input  logic [dibm_pkg::IDX_W-1:0]   in_second_index_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   out_status_o,
  output logic [dibm_pkg::SLOT_W-1:0]  out_sample_slot_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dibm_pkg::CIDX_W-1:0]  cfg_index_i,
  input  logic [dibm_pkg::CFG_W-1:0]   cfg_data_i
);

  localparam int unsigned DEPTH = LANES * SAMPLES_PER_LANE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned LW    = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned CW    = $clog2(SAMPLES_PER_LANE + 1);
  localparam int unsigned EW    = $clog2(SAMPLES_PER_LANE);
  localparam int unsigned DW    = $clog2(INDEX_BASES + 2);
  localparam int unsigned NC    = INDEX_BASES;
  localparam int unsigned IW    = dibm_pkg::IDX_W;
  localparam int unsigned BW    = dibm_pkg::BASE_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_FIN} state_e;

  state_e                          state_q;
  logic [CW-1:0]                   cnt_q [LANES];
  logic [dibm_pkg::CFG_W-1:0]      maxe_q, ilen_q;
  logic                            out_valid_q;
  dibm_pkg::status_e               out_status_q, res_q;
  logic [dibm_pkg::SLOT_W-1:0]     out_slot_q, res_slot_q;
  logic [IW-1:0]                   r7_q, r5_q;
  logic [AW-1:0]                   base_q;
  logic [CW-1:0]                   scnt_q;
  logic [4:0]                      bases_q;
  logic [EW-1:0]                   e_q, rd_tag_q, best_q;
  logic [DW-1:0]                   bd7_q, bd5_q;
  logic                            done_q, rd_vld_q;
  dibm_pkg::pair_t                 rdata_q;
  dibm_pkg::pair_t                 mem [DEPTH];

  logic                            in_acc, lane_ok, full, mem_we, out_free;
  logic [LW-1:0]                   lidx;
  logic [CW-1:0]                   cur_cnt;
  logic [AW-1:0]                   lane_base, waddr, raddr;
  logic [4:0]                      bases_d;

  logic                            c_vld  [NC+1];
  logic [EW-1:0]                   c_tag  [NC+1];
  logic [DW-1:0]                   c_d7   [NC+1];
  logic [DW-1:0]                   c_d5   [NC+1];
  dibm_pkg::pair_t                 c_pair [NC+1];

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign lane_ok   = (in_lane_i != 4'd0) && ({1'b0, in_lane_i} <= 5'(LANES));
  assign lidx      = LW'(in_lane_i - 4'd1);
  assign cur_cnt   = lane_ok ? cnt_q[lidx] : '0;
  assign full      = (cur_cnt >= CW'(SAMPLES_PER_LANE));
  assign lane_base = AW'(lidx) * AW'(SAMPLES_PER_LANE);
  assign waddr     = lane_base + AW'(cur_cnt);
  assign raddr     = base_q + AW'(e_q);
  assign mem_we    = in_acc && (in_command_i == dibm_pkg::CMD_INSERT) && lane_ok && !full;
  assign bases_d   = (5'(ilen_q) > 5'(INDEX_BASES)) ? 5'(INDEX_BASES) : 5'(ilen_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= '{w7: in_first_index_i, w5: in_second_index_i};
    end
    if (state_q == S_SCAN) begin
      rdata_q <= mem[raddr];
    end
  end

  assign c_vld[0]  = rd_vld_q;
  assign c_tag[0]  = rd_tag_q;
  assign c_d7[0]   = '0;
  assign c_d5[0]   = '0;
  assign c_pair[0] = rdata_q;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    logic [BW-1:0] rb7, rb5;
    if ((k + 1) * BW <= IW) begin : g_base
      assign rb7 = r7_q[k*BW +: BW];
      assign rb5 = r5_q[k*BW +: BW];
    end else begin : g_zero
      assign rb7 = '0;
      assign rb5 = '0;
    end
    dibm_cell #(.EW(EW), .DW(DW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (c_vld[k]),
      .tag_i  (c_tag[k]),
      .d7_i   (c_d7[k]),
      .d5_i   (c_d5[k]),
      .pair_i (c_pair[k]),
      .r7_i   (rb7),
      .r5_i   (rb5),
      .en_i   (5'(k) < bases_q),
      .vld_o  (c_vld[k+1]),
      .tag_o  (c_tag[k+1]),
      .d7_o   (c_d7[k+1]),
      .d5_o   (c_d5[k+1]),
      .pair_o (c_pair[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
      done_q      <= 1'b0;
      maxe_q      <= dibm_pkg::MAX_ERRORS_RST;
      ilen_q      <= dibm_pkg::INDEX_LENGTH_RST;
      for (int i = 0; i < LANES; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          dibm_pkg::REG_MAX_ERRORS:   maxe_q <= cfg_data_i;
          dibm_pkg::REG_INDEX_LENGTH: ilen_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      rd_vld_q <= (state_q == S_SCAN);
      if (c_vld[NC]) begin
        if (c_d7[NC] < bd7_q) begin
          bd7_q  <= c_d7[NC];
          bd5_q  <= c_d5[NC];
          best_q <= c_tag[NC];
        end
        if (CW'(c_tag[NC]) + CW'(1) == scnt_q) begin
          done_q <= 1'b1;
        end
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            res_slot_q <= '0;
            state_q    <= S_FIN;
            if (!lane_ok) begin
              res_q <= dibm_pkg::ST_NO_LANE;
            end else if (in_command_i == dibm_pkg::CMD_INSERT) begin
              if (full) begin
                res_q <= dibm_pkg::ST_FULL;
              end else begin
                res_q        <= dibm_pkg::ST_INSERTED;
                res_slot_q   <= dibm_pkg::SLOT_W'(cur_cnt);
                cnt_q[lidx]  <= cur_cnt + CW'(1);
              end
            end else if (cur_cnt == '0) begin
              res_q <= dibm_pkg::ST_NO_LANE;
            end else begin
              r7_q    <= in_first_index_i;
              r5_q    <= in_second_index_i;
              base_q  <= lane_base;
              scnt_q  <= cur_cnt;
              bases_q <= bases_d;
              e_q     <= '0;
              bd7_q   <= '1;
              bd5_q   <= '1;
              best_q  <= '0;
              done_q  <= 1'b0;
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rd_tag_q <= e_q;
          e_q      <= e_q + EW'(1);
          if (CW'(e_q) + CW'(1) == scnt_q) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (done_q) begin
            if ((8'(bd7_q) <= 8'(maxe_q)) && (8'(bd5_q) <= 8'(maxe_q))) begin
              res_q      <= dibm_pkg::ST_MATCHED;
              res_slot_q <= dibm_pkg::SLOT_W'(best_q);
            end else begin
              res_q      <= dibm_pkg::ST_UNDETERMINED;
              res_slot_q <= dibm_pkg::SLOT_W'(scnt_q);
            end
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_q;
            out_slot_q   <= res_slot_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = out_status_q;
  assign out_sample_slot_o = out_slot_q;

  `DIBM_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_q != S_IDLE,
                    "transfer accepted but block stayed idle")
  `DIBM_ASSERT(a_scan_in_range, (state_q == S_SCAN) |-> (CW'(e_q) < scnt_q),
               "scan index beyond lane entry count")
  `DIBM_ASSERT(a_chain_only_busy, c_vld[NC] |-> (state_q == S_SCAN || state_q == S_DRAIN),
               "compare chain output outside a scan")
  `DIBM_ASSERT_NEXT(a_drain_done, state_q == S_DRAIN && done_q, state_q == S_FIN,
                    "finished scan did not produce a result")

endmodule

// ===== rtl/dibm_cell.sv =====
module dibm_cell #(
  parameter int unsigned EW = 6,
  parameter int unsigned DW = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        vld_i,
  input  logic [EW-1:0]               tag_i,
  input  logic [DW-1:0]               d7_i,
  input  logic [DW-1:0]               d5_i,
  input  dibm_pkg::pair_t             pair_i,
  input  logic [dibm_pkg::BASE_W-1:0] r7_i,
  input  logic [dibm_pkg::BASE_W-1:0] r5_i,
  input  logic                        en_i,
  output logic                        vld_o,
  output logic [EW-1:0]               tag_o,
  output logic [DW-1:0]               d7_o,
  output logic [DW-1:0]               d5_o,
  output dibm_pkg::pair_t             pair_o
);

  logic            vld_q;
  logic [EW-1:0]   tag_q;
  logic [DW-1:0]   d7_q, d7_d, d5_q, d5_d;
  dibm_pkg::pair_t pair_q, pair_d;
  logic            mis7, mis5;

  assign mis7 = en_i && (pair_i.w7[dibm_pkg::BASE_W-1:0] != r7_i);
  assign mis5 = en_i && (pair_i.w5[dibm_pkg::BASE_W-1:0] != r5_i);
  assign d7_d = d7_i + DW'(mis7);
  assign d5_d = d5_i + DW'(mis5);
  assign pair_d.w7 = pair_i.w7 >> dibm_pkg::BASE_W;
  assign pair_d.w5 = pair_i.w5 >> dibm_pkg::BASE_W;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q  <= tag_i;
    d7_q   <= d7_d;
    d5_q   <= d5_d;
    pair_q <= pair_d;
  end

  assign vld_o  = vld_q;
  assign tag_o  = tag_q;
  assign d7_o   = d7_q;
  assign d5_o   = d5_q;
  assign pair_o = pair_q;

endmodule

// ===== verif/dual_index_barcode_matcher_checker.sv =====
module dual_index_barcode_matcher_checker
  import dibm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              in_command_i,
  input  logic [3:0]        in_lane_i,
  input  logic [IDX_W-1:0]  in_first_index_i,
  input  logic [IDX_W-1:0]  in_second_index_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [2:0]        out_status_i,
  input  logic [SLOT_W-1:0] out_sample_slot_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [CIDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  output int                errors_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
  } verdict_t;

  logic [IDX_W-1:0] i7_table [LANES*SAMPLES_PER_LANE];
  logic [IDX_W-1:0] i5_table [LANES*SAMPLES_PER_LANE];
  int unsigned      entries  [LANES];
  logic [CFG_W-1:0] err_limit;
  logic [CFG_W-1:0] bases_cfg;
  verdict_t         awaited [$];
  int               mismatches;

  assign errors_o  = mismatches;
  assign pending_o = awaited.size();

  function automatic int unsigned base_diff(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                                            int unsigned n);
    int unsigned d;
    d = 0;
    for (int unsigned i = 0; i < n; i++)
      if (a[3*i +: 3] != b[3*i +: 3]) d++;
    return d;
  endfunction

  function automatic verdict_t classify_or_insert(logic cmd, logic [3:0] lane,
                                                  logic [IDX_W-1:0] i7, logic [IDX_W-1:0] i5);
    verdict_t    v;
    int unsigned n, cnt, row, best, best_d, d;
    v.status = ST_NO_LANE;
    v.slot   = '0;
    n = (bases_cfg > INDEX_BASES) ? INDEX_BASES : bases_cfg;
    if (lane != 0 && lane <= LANES) begin
      cnt = entries[lane-1];
      row = (lane - 1) * SAMPLES_PER_LANE;
      if (cmd == CMD_INSERT) begin
        if (cnt >= SAMPLES_PER_LANE) begin
          v.status = ST_FULL;
        end else begin
          i7_table[row+cnt] = i7;
          i5_table[row+cnt] = i5;
          entries[lane-1]   = cnt + 1;
          v.status = ST_INSERTED;
          v.slot   = cnt[SLOT_W-1:0];
        end
      end else if (cnt != 0) begin
        best   = 0;
        best_d = 32'hFFFF_FFFF;
        for (int unsigned e = 0; e < cnt; e++) begin
          d = base_diff(i7_table[row+e], i7, n);
          if (d < best_d) begin
            best_d = d;
            best   = e;
          end
        end
        if (best_d <= err_limit && base_diff(i5_table[row+best], i5, n) <= err_limit) begin
          v.status = ST_MATCHED;
          v.slot   = best[SLOT_W-1:0];
        end else begin
          v.status = ST_UNDETERMINED;
          v.slot   = cnt[SLOT_W-1:0];
        end
      end
    end
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t v;
    if (!rst_ni) begin
      foreach (entries[i]) entries[i] = 0;
      err_limit  = MAX_ERRORS_RST;
      bases_cfg  = INDEX_LENGTH_RST;
      awaited.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_MAX_ERRORS) err_limit = cfg_data_i;
        else if (cfg_index_i == REG_INDEX_LENGTH) bases_cfg = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (awaited.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0d slot %0d", out_status_i,
                     out_sample_slot_i);
        end else begin
          v = awaited.pop_front();
          if (out_status_i != v.status || out_sample_slot_i != v.slot) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected status %0d slot %0d, got status %0d slot %0d",
                       v.status, v.slot, out_status_i, out_sample_slot_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        v = classify_or_insert(in_command_i, in_lane_i, in_first_index_i, in_second_index_i);
        awaited.insert(awaited.size(), v);
      end
    end
  end

endmodule

// ===== verif/dual_index_barcode_matcher_unit_tb.sv =====
module dual_index_barcode_matcher_unit_tb;
  import dibm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              in_command_i = CMD_INSERT;
  logic [3:0]        in_lane_i = '0;
  logic [IDX_W-1:0]  in_first_index_i = '0;
  logic [IDX_W-1:0]  in_second_index_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [2:0]        out_status_o;
  logic [SLOT_W-1:0] out_sample_slot_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CIDX_W-1:0] cfg_index_i = REG_MAX_ERRORS;
  logic [CFG_W-1:0]  cfg_data_i = '0;
  int                errors;
  int                pending;

  bit                idling = 1'b1;
  bit                hold_req = 1'b0;
  int                sent = 0;
  logic [IDX_W-1:0]  lane_i7 [LANES][$];
  logic [IDX_W-1:0]  lane_i5 [LANES][$];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  dual_index_barcode_matcher_unit dut (.*);

  dual_index_barcode_matcher_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_command_i, .in_lane_i,
    .in_first_index_i, .in_second_index_i, .out_valid_i(out_valid_o), .out_stall_i,
    .out_status_i(out_status_o), .out_sample_slot_i(out_sample_slot_o), .cfg_valid_i,
    .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i, .errors_o(errors),
    .pending_o(pending)
  );

  initial begin
    #8ms;
    $display("status: fail");
    $finish;
  end

  // receiver: random stalls, plus one long hold
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= idling && ($urandom_range(99) < 34);
      end
    end
  end

  task automatic send(logic cmd, logic [3:0] lane, logic [IDX_W-1:0] i7,
                      logic [IDX_W-1:0] i5);
    while (idling && $urandom_range(99) < 34) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i        <= 1'b1;
    in_command_i      <= cmd;
    in_lane_i         <= lane;
    in_first_index_i  <= i7;
    in_second_index_i <= i5;
    do @(posedge clk_i); while (in_stall_o);
    if (cmd == CMD_INSERT && lane != 0 && lane <= LANES &&
        lane_i7[lane-1].size() < SAMPLES_PER_LANE) begin
      lane_i7[lane-1].insert(lane_i7[lane-1].size(), i7);
      lane_i5[lane-1].insert(lane_i5[lane-1].size(), i5);
    end
    sent++;
    if (sent == 500) hold_req = 1'b1;
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic configure(logic [CFG_W-1:0] max_err, logic [CFG_W-1:0] len);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_MAX_ERRORS;
    cfg_data_i  <= max_err;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_index_i <= REG_INDEX_LENGTH;
    cfg_data_i  <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [IDX_W-1:0] mutate(logic [IDX_W-1:0] v, int unsigned k);
    int unsigned b;
    for (int unsigned i = 0; i < k; i++) begin
      b = $urandom_range(INDEX_BASES - 1);
      v[3*b +: 3] = v[3*b +: 3] + 3'($urandom_range(7, 1));
    end
    return v;
  endfunction

  task automatic random_item();
    int unsigned      pick, lane, e;
    logic [IDX_W-1:0] r7, r5;
    pick = $urandom_range(99);
    r7   = IDX_W'($urandom);
    r5   = IDX_W'($urandom);
    lane = $urandom_range(LANES, 1);
    if (pick < 10) begin
      send(1'($urandom), 4'($urandom), r7, r5);
    end else if (pick < 25 || lane_i7[lane-1].size() == 0) begin
      send(CMD_INSERT, 4'(lane), r7, r5);
    end else begin
      e = $urandom_range(lane_i7[lane-1].size() - 1);
      send(CMD_CLASSIFY, 4'(lane), mutate(lane_i7[lane-1][e], $urandom_range(3)),
           mutate(lane_i5[lane-1][e], $urandom_range(3)));
    end
  endtask

  initial begin
    logic [CFG_W-1:0] err_set [7] = '{4'd1, 4'd0, 4'd10, 4'd15, 4'd2, 4'd3, 4'd1};
    logic [CFG_W-1:0] len_set [7] = '{4'd8, 4'd10, 4'd1, 4'd15, 4'd0, 4'd5, 4'd4};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send(CMD_CLASSIFY, 4'd1, '0, '0);
    send(CMD_INSERT, 4'd0, '1, '1);
    send(CMD_INSERT, 4'd9, '0, '1);
    send(CMD_CLASSIFY, 4'd15, '1, '0);
    send(CMD_INSERT, 4'd1, '0, '0);
    send(CMD_INSERT, 4'd1, '1, '1);
    send(CMD_INSERT, 4'd1, 30'h0924_9249, 30'h1249_2492);
    send(CMD_CLASSIFY, 4'd1, '0, '0);
    send(CMD_CLASSIFY, 4'd1, '1, '1);
    send(CMD_CLASSIFY, 4'd1, 30'h0000_0001, 30'h0000_0000);
    send(CMD_CLASSIFY, 4'd1, 30'h0000_0009, 30'h0000_0000);
    send(CMD_CLASSIFY, 4'd1, '0, 30'h0000_0049);
    send(CMD_CLASSIFY, 4'd1, 30'h3FFF_0000, 30'h3FFF_0000);
    send(CMD_CLASSIFY, 4'd1, 30'h0924_9249, 30'h1249_2492);
    send(CMD_INSERT, 4'd8, 30'h2AAA_AAAA, 30'h1555_5555);
    send(CMD_CLASSIFY, 4'd8, 30'h2AAA_AAAA, 30'h1555_5555);
    send(CMD_CLASSIFY, 4'd8, 30'h1555_5555, 30'h2AAA_AAAA);
    send(CMD_CLASSIFY, 4'd2, '1, '1);
    send(CMD_CLASSIFY, 4'd0, '0, '0);

    for (int p = 0; p < 7; p++) begin
      configure(err_set[p], len_set[p]);
      if (p == 2)
        repeat (66) send(CMD_INSERT, 4'd3, IDX_W'($urandom), IDX_W'($urandom));
      if (p == 3) idling = 1'b0;
      if (p == 4) idling = 1'b1;
      repeat (p == 2 ? 125 : 190) random_item();
    end

    settle();
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== dual_index_barcode_matcher_unit.f =====
+incdir+rtl
rtl/dibm_pkg.sv
rtl/dibm_cell.sv
rtl/dual_index_barcode_matcher_unit.sv
verif/dual_index_barcode_matcher_checker.sv
verif/dual_index_barcode_matcher_unit_tb.sv
